FILE: hw/rtl/fsfa_pkg.sv
// Shared types, codes and defaults for the free segment fit allocator.
package fsfa_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int SIZE_BITS_DEF    = 32;

    localparam int STATUS_W   = 3;
    localparam int POS_W      = 5;
    localparam int HELD_W     = 5;
    localparam int POLICY_W   = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HALTED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd5;

    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam logic REG_FIT_POLICY = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_WAIT,
        S_DECIDE,
        S_SHIFT,
        S_SHIFT_WAIT,
        S_RESULT
    } state_t;

endpackage

FILE: hw/rtl/fsfa_fit_track.sv
// Candidate tracker: keeps the slot chosen so far during a scan.
module fsfa_fit_track #(
    parameter int MAX_SEGMENTS = fsfa_pkg::MAX_SEGMENTS_DEF,
    parameter int SIZE_BITS    = fsfa_pkg::SIZE_BITS_DEF,
    localparam int IDX_W       = $clog2(MAX_SEGMENTS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 best_mode,
    input  logic                 sample_valid,
    input  logic [IDX_W-1:0]     sample_idx,
    input  logic [SIZE_BITS-1:0] sample_size,
    input  logic [SIZE_BITS-1:0] request,
    output logic                 found,
    output logic [IDX_W-1:0]     best_idx,
    output logic [SIZE_BITS-1:0] best_left
);

    logic                 found_reg;
    logic                 found_next;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [IDX_W-1:0]     best_idx_next;
    logic [SIZE_BITS-1:0] best_left_reg;
    logic [SIZE_BITS-1:0] best_left_next;
    logic                 fits;
    logic [SIZE_BITS-1:0] left;
    logic                 take;

    always_comb
    begin
        fits           = sample_size >= request;
        left           = sample_size - request;
        take           = sample_valid && fits &&
                         (!found_reg || (best_mode && (left < best_left_reg)));
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_left_next = best_left_reg;
        if (clear)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next     = 1'b1;
            best_idx_next  = sample_idx;
            best_left_next = left;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_left_reg <= best_left_next;
    end

    assign found     = found_reg;
    assign best_idx  = best_idx_reg;
    assign best_left = best_left_reg;

endmodule

FILE: hw/rtl/free_segment_fit_allocator.sv
// Top level: segment list in memory, fit scan and shift-down sequencer.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, opcode, amount         | into block
//  out     | out_valid, out_ready, status, slot_position,| out of block
//          | leftover, segments_held                    |
//  cfg     | psel, penable, pwrite, paddr, pwdata,       | APB slave
//          | prdata, pready                             |
//
// Loads and early-out requests skip the scan. A request scans the list through the
// memory read port, one slot per cycle, then shifts the later slots down when the
// chosen slot empties and is not the last one.
// Reset clears the count, roving pointer, halt flag and policy; memory is not cleared.
// A new item is taken while a finished result waits on a stalled out channel.
module free_segment_fit_allocator #(
    parameter int MAX_SEGMENTS = fsfa_pkg::MAX_SEGMENTS_DEF,
    parameter int SIZE_BITS    = fsfa_pkg::SIZE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            opcode,
    input  logic [SIZE_BITS-1:0]            amount,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fsfa_pkg::STATUS_W-1:0]   status,
    output logic [fsfa_pkg::POS_W-1:0]      slot_position,
    output logic [SIZE_BITS-1:0]            leftover,
    output logic [fsfa_pkg::HELD_W-1:0]     segments_held,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fsfa_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [fsfa_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [fsfa_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    fsfa_pkg::state_t state_reg;
    fsfa_pkg::state_t state_next;

    logic [fsfa_pkg::POLICY_W-1:0] policy_reg;
    logic [fsfa_pkg::POLICY_W-1:0] policy_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [IDX_W-1:0]              rov_reg;
    logic [IDX_W-1:0]              rov_next;
    logic                          halted_reg;
    logic                          halted_next;

    logic [SIZE_BITS-1:0]          req_reg;
    logic [SIZE_BITS-1:0]          req_next;
    logic [IDX_W-1:0]              addr_reg;
    logic [IDX_W-1:0]              addr_next;
    logic [CNT_W-1:0]              scan_cnt_reg;
    logic [CNT_W-1:0]              scan_cnt_next;
    logic                          pv_reg;
    logic [IDX_W-1:0]              pidx_reg;
    logic                          wv_reg;
    logic [IDX_W-1:0]              waddr_reg;

    logic [fsfa_pkg::STATUS_W-1:0] pend_status_reg;
    logic [fsfa_pkg::STATUS_W-1:0] pend_status_next;
    logic [CNT_W-1:0]              pend_pos_reg;
    logic [CNT_W-1:0]              pend_pos_next;
    logic [SIZE_BITS-1:0]          pend_left_reg;
    logic [SIZE_BITS-1:0]          pend_left_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [fsfa_pkg::STATUS_W-1:0] status_reg;
    logic [CNT_W-1:0]              pos_reg;
    logic [SIZE_BITS-1:0]          left_reg;
    logic [CNT_W-1:0]              held_reg;

    logic [SIZE_BITS-1:0]          mem [MAX_SEGMENTS];
    logic [SIZE_BITS-1:0]          mem_q;
    logic                          mem_we;
    logic [IDX_W-1:0]              mem_waddr;
    logic [SIZE_BITS-1:0]          mem_wdata;

    logic                          accept;
    logic                          out_load;
    logic                          track_clear;
    logic                          found;
    logic [IDX_W-1:0]              best_idx;
    logic [SIZE_BITS-1:0]          best_left;
    logic [CNT_W-1:0]              best_pos;
    logic [CNT_W-1:0]              count_dec;
    logic                          last_scan;
    logic                          last_shift;
    logic                          cfg_write;

    assign accept     = in_valid && in_ready;
    assign out_load   = (state_reg == fsfa_pkg::S_RESULT) && (!out_valid_reg || out_ready);
    assign best_pos   = CNT_W'(best_idx) + CNT_W'(1);
    assign count_dec  = count_reg - CNT_W'(1);
    assign last_scan  = scan_cnt_reg == count_dec;
    assign last_shift = CNT_W'(addr_reg) == count_reg;

    assign cfg_write = psel && penable && pwrite &&
                       (paddr[fsfa_pkg::CFG_ADDR_W-1] == fsfa_pkg::REG_FIT_POLICY);
    assign pready    = 1'b1;
    assign prdata    = (paddr[fsfa_pkg::CFG_ADDR_W-1] == fsfa_pkg::REG_FIT_POLICY) ?
                       fsfa_pkg::CFG_DATA_W'(policy_reg) : '0;

    fsfa_fit_track #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .SIZE_BITS    (SIZE_BITS)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (track_clear),
        .best_mode    (policy_reg == fsfa_pkg::POL_BEST),
        .sample_valid (pv_reg),
        .sample_idx   (pidx_reg),
        .sample_size  (mem_q),
        .request      (req_reg),
        .found        (found),
        .best_idx     (best_idx),
        .best_left    (best_left)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fsfa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if ((opcode == fsfa_pkg::OP_ALLOC) && !halted_reg &&
                        (amount != '0) && (count_reg != '0))
                    begin
                        state_next = fsfa_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = fsfa_pkg::S_RESULT;
                    end
                end
            end
            fsfa_pkg::S_SCAN:
            begin
                if (last_scan)
                begin
                    state_next = fsfa_pkg::S_SCAN_WAIT;
                end
            end
            fsfa_pkg::S_SCAN_WAIT:
            begin
                state_next = fsfa_pkg::S_DECIDE;
            end
            fsfa_pkg::S_DECIDE:
            begin
                if (found && (best_left == '0) && (best_pos != count_reg))
                begin
                    state_next = fsfa_pkg::S_SHIFT;
                end
                else
                begin
                    state_next = fsfa_pkg::S_RESULT;
                end
            end
            fsfa_pkg::S_SHIFT:
            begin
                if (last_shift)
                begin
                    state_next = fsfa_pkg::S_SHIFT_WAIT;
                end
            end
            fsfa_pkg::S_SHIFT_WAIT:
            begin
                state_next = fsfa_pkg::S_RESULT;
            end
            fsfa_pkg::S_RESULT:
            begin
                if (out_load)
                begin
                    state_next = fsfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fsfa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready         = state_reg == fsfa_pkg::S_IDLE;
        policy_next      = cfg_write ? pwdata[fsfa_pkg::POLICY_W-1:0] : policy_reg;
        count_next       = count_reg;
        rov_next         = rov_reg;
        halted_next      = halted_reg;
        req_next         = req_reg;
        addr_next        = addr_reg;
        scan_cnt_next    = scan_cnt_reg;
        pend_status_next = pend_status_reg;
        pend_pos_next    = pend_pos_reg;
        pend_left_next   = pend_left_reg;
        track_clear      = 1'b0;
        mem_we           = wv_reg;
        mem_waddr        = waddr_reg;
        mem_wdata        = mem_q;
        unique case (state_reg)
            fsfa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    pend_pos_next  = '0;
                    pend_left_next = '0;
                    if (opcode == fsfa_pkg::OP_LOAD)
                    begin
                        if (amount == '0)
                        begin
                            pend_status_next = fsfa_pkg::ST_ZERO;
                        end
                        else if (count_reg >= CNT_W'(MAX_SEGMENTS))
                        begin
                            pend_status_next = fsfa_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we           = 1'b1;
                            mem_waddr        = IDX_W'(count_reg);
                            mem_wdata        = amount;
                            count_next       = count_reg + CNT_W'(1);
                            pend_status_next = fsfa_pkg::ST_LOADED;
                            pend_pos_next    = count_reg + CNT_W'(1);
                        end
                    end
                    else if (halted_reg)
                    begin
                        pend_status_next = fsfa_pkg::ST_HALTED;
                    end
                    else if (amount == '0)
                    begin
                        pend_status_next = fsfa_pkg::ST_ZERO;
                    end
                    else if (count_reg == '0)
                    begin
                        pend_status_next = fsfa_pkg::ST_NO_FIT;
                        halted_next      = 1'b1;
                    end
                    else
                    begin
                        req_next      = amount;
                        scan_cnt_next = '0;
                        track_clear   = 1'b1;
                        if ((policy_reg == fsfa_pkg::POL_NEXT) &&
                            (CNT_W'(rov_reg) < count_reg))
                        begin
                            addr_next = rov_reg;
                        end
                        else
                        begin
                            addr_next = '0;
                        end
                    end
                end
            end
            fsfa_pkg::S_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (CNT_W'(addr_reg) == count_dec)
                begin
                    addr_next = '0;
                end
                else
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            fsfa_pkg::S_DECIDE:
            begin
                pend_pos_next  = '0;
                pend_left_next = '0;
                if (!found)
                begin
                    pend_status_next = fsfa_pkg::ST_NO_FIT;
                    halted_next      = 1'b1;
                end
                else
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = best_idx;
                    mem_wdata        = best_left;
                    pend_status_next = fsfa_pkg::ST_ALLOCATED;
                    pend_pos_next    = best_pos;
                    pend_left_next   = best_left;
                    if (best_left != '0)
                    begin
                        rov_next = (best_pos >= count_reg) ? '0 : IDX_W'(best_pos);
                    end
                    else
                    begin
                        count_next = count_dec;
                        rov_next   = (CNT_W'(best_idx) >= count_dec) ? '0 : best_idx;
                        addr_next  = IDX_W'(best_pos);
                    end
                end
            end
            fsfa_pkg::S_SHIFT:
            begin
                addr_next = addr_reg + IDX_W'(1);
            end
            fsfa_pkg::S_SCAN_WAIT,
            fsfa_pkg::S_SHIFT_WAIT,
            fsfa_pkg::S_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fsfa_pkg::S_IDLE;
            policy_reg    <= fsfa_pkg::POL_FIRST;
            count_reg     <= '0;
            rov_reg       <= '0;
            halted_reg    <= 1'b0;
            pv_reg        <= 1'b0;
            wv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            policy_reg    <= policy_next;
            count_reg     <= count_next;
            rov_reg       <= rov_next;
            halted_reg    <= halted_next;
            pv_reg        <= state_reg == fsfa_pkg::S_SCAN;
            wv_reg        <= state_reg == fsfa_pkg::S_SHIFT;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        addr_reg        <= addr_next;
        scan_cnt_reg    <= scan_cnt_next;
        pidx_reg        <= addr_reg;
        waddr_reg       <= addr_reg - IDX_W'(1);
        pend_status_reg <= pend_status_next;
        pend_pos_reg    <= pend_pos_next;
        pend_left_reg   <= pend_left_next;
        if (out_load)
        begin
            status_reg <= pend_status_reg;
            pos_reg    <= pend_pos_reg;
            left_reg   <= pend_left_reg;
            held_reg   <= count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[addr_reg];
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign slot_position = fsfa_pkg::POS_W'(pos_reg);
    assign leftover      = left_reg;
    assign segments_held = fsfa_pkg::HELD_W'(held_reg);

endmodule
